@@ rtl/prm_pkg.sv @@
`timescale 1ns / 1ps
package prm_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_W           = $clog2(MAX_RESULTS + 1);
  localparam logic [7:0]  DEF_MAX_AGE = 8'd180;
  localparam logic [19:0] TOTAL_MAX   = 20'hFFFFF;

  typedef enum logic [2:0] {
    OP_SUBMIT = 3'd0,
    OP_CONFIRM = 3'd1,
    OP_CANCEL = 3'd2,
    OP_LIST = 3'd3,
    OP_COUNT = 3'd4,
    OP_TICK = 3'd5,
    OP_FLUSH = 3'd6,
    OP_CLEAR = 3'd7
  } op_t;

  localparam logic [2:0] KIND_CONFIRMED = 3'd0;
  localparam logic [2:0] KIND_NO_MATCH  = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_EXPIRED   = 3'd3;
  localparam logic [2:0] KIND_OUTGOING  = 3'd4;
  localparam logic [2:0] KIND_FULL      = 3'd5;

  localparam logic REG_ENABLED = 1'b0;
  localparam logic REG_MAX_AGE = 1'b1;

  typedef struct packed {
    logic [31:0]        form;
    logic signed [15:0] delta;
    logic [7:0]         tag;
    logic               is_use;
    logic [15:0]        uid;
    logic [15:0]        sig;
    logic [15:0]        slot;
    logic [7:0]         age;
  } entry_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        form;
    logic signed [15:0] delta;
    logic [7:0]         tag;
    logic [15:0]        uid;
    logic [15:0]        sig;
    logic [15:0]        slot;
    logic [19:0]        total;
    logic               amb;
  } res_t;

endpackage

@@ rtl/pending_request_matcher.sv @@
`timescale 1ns / 1ps
// Pending request matcher: an age-ordered table of open requests, oldest first.
// Input channel (in_valid/in_ready) takes one operation word: submit, confirm,
// cancel, list, count, tick, flush or clear. Result words leave on the output
// channel (out_valid/out_ready); the final word of each operation has last set.
// Configuration (enable, max_age) sits on the APB port; write only when idle.
// Rate: one operation at a time. Submit and clear need no pass. When enabled,
// the others make one compacting pass over the table held in a single RAM with
// a registered read: each open entry is read, then evaluated and written back,
// and the pass sits between accept and start steps and finish and hand-off steps.
// Removed entries are squeezed out during the pass, so order is kept.
// Results go through a one-word hold stage (to know which word is last) and
// an output register; while the receiver stalls, the pass waits at the entry
// that wants to report and resumes when the output register frees up.
// Reset empties the table (count to zero, no clearing pass: entries beyond the
// count are never read), sets enabled to 1 and max_age to 180.
module pending_request_matcher
  import prm_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [31:0]        form_id,
  input  logic signed [15:0] delta,
  input  logic [7:0]         requester_tag,
  input  logic               is_use,
  input  logic [15:0]        request_uid,
  input  logic [15:0]        request_sig,
  input  logic [15:0]        slot_id,
  input  logic [15:0]        cancel_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         result_kind,
  output logic [31:0]        out_form_id,
  output logic signed [15:0] out_delta,
  output logic [7:0]         out_requester_tag,
  output logic [15:0]        out_uid,
  output logic [15:0]        out_sig,
  output logic [15:0]        out_slot_id,
  output logic [19:0]        outgoing_total,
  output logic               ambiguous,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {S_IDLE, S_START, S_RD, S_EV, S_FIN, S_DRAIN} state_t;

  state_t state;
  logic   enabled;
  logic [7:0] max_age;

  // latched operation word
  op_t                op;
  logic [31:0]        r_form;
  logic signed [15:0] r_delta;
  logic [7:0]         r_tag;
  logic               r_use;
  logic [15:0]        r_uid, r_sig, r_slot;

  logic [CW-1:0]    open_count, rd, wr;
  logic [15:0]      left;
  logic [RES_W-1:0] n;
  logic [1:0]       cand;
  logic             expiring;
  logic [19:0]      total;
  entry_t           first;

  res_t pend;
  logic pend_valid;
  res_t out_r;

  // RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, e;

  prm_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(e)
  );

  // config port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_ENABLED: prdata = {31'd0, enabled};
      default:     prdata = {24'd0, max_age};
    endcase
  end

  // evaluation of one entry
  logic        outg, is_match, ev_keep, ev_emit, ev_go, overdue, room;
  entry_t      ev_entry;
  res_t        ev_res;
  logic [15:0] units, take;
  logic [7:0]  age_new;
  logic [20:0] sum;
  logic        out_free, sub_we, full;

  assign out_free = !out_valid || out_ready;
  assign full     = open_count >= CW'(TABLE_DEPTH);
  assign sub_we   = state == S_START && enabled && op == OP_SUBMIT &&
                    r_delta != 16'sd0 && !full;
  assign room     = n < RES_W'(MAX_RESULTS);

  always_comb begin
    outg     = e.form == r_form && e.delta < 0 && !e.is_use;
    is_match = e.form == r_form && ((e.delta < 0) == (r_delta < 0));
    units    = 16'(-e.delta);
    take     = (units < left) ? units : left;
    age_new  = (e.age == 8'hFF) ? 8'hFF : e.age + 8'd1;
    sum      = 21'(total) + 21'(units);
    if (rd == '0) begin
      overdue = (9'(e.age) + 9'd1) > 9'(max_age);
    end else begin
      overdue = age_new > max_age || (age_new == 8'hFF && max_age == 8'hFF);
    end
    ev_keep  = 1'b1;
    ev_emit  = 1'b0;
    ev_entry = e;
    ev_res   = '0;
    ev_res.form  = e.form;
    ev_res.delta = e.delta;
    ev_res.tag   = e.tag;
    ev_res.uid   = e.uid;
    ev_res.sig   = e.sig;
    ev_res.slot  = e.slot;
    case (op)
      OP_CONFIRM: begin
        if (is_match && cand == 2'd0) ev_keep = 1'b0;
      end
      OP_CANCEL: begin
        if (outg && left != 16'd0 && room) begin
          ev_emit       = 1'b1;
          ev_res.kind   = KIND_CANCELLED;
          ev_res.delta  = 16'(-take);
          ev_keep       = take != units;
          ev_entry.delta = e.delta + $signed(take);
        end
      end
      OP_LIST: begin
        if (outg && room) begin
          ev_emit     = 1'b1;
          ev_res.kind = KIND_OUTGOING;
        end
      end
      OP_TICK: begin
        ev_entry.age = age_new;
        if (expiring && room && overdue) begin
          ev_emit     = 1'b1;
          ev_keep     = 1'b0;
          ev_res.kind = KIND_EXPIRED;
        end
      end
      OP_FLUSH: begin
        if (room) begin
          ev_emit     = 1'b1;
          ev_keep     = 1'b0;
          ev_res.kind = KIND_EXPIRED;
        end
      end
      default: ;
    endcase
    ev_go = !ev_emit || !pend_valid || out_free;
  end

  // a held word moves into the output register: displaced by a new one
  // during the pass, or as the final word of the operation
  logic out_load;
  assign out_load = (state == S_EV && ev_go && ev_emit && pend_valid) ||
                    (state == S_DRAIN && pend_valid && out_free);

  always_comb begin
    ram_raddr = rd[IW-1:0];
    if (sub_we) begin
      ram_we    = 1'b1;
      ram_waddr = open_count[IW-1:0];
      ram_wdata = '{form: r_form, delta: r_delta, tag: r_tag, is_use: r_use,
                    uid: r_uid, sig: r_sig, slot: r_slot, age: 8'd0};
    end else begin
      ram_we    = state == S_EV && ev_go && ev_keep;
      ram_waddr = wr[IW-1:0];
      ram_wdata = ev_entry;
    end
  end

  assign in_ready = state == S_IDLE;

  assign result_kind       = out_r.kind;
  assign out_form_id       = out_r.form;
  assign out_delta         = out_r.delta;
  assign out_requester_tag = out_r.tag;
  assign out_uid           = out_r.uid;
  assign out_sig           = out_r.sig;
  assign out_slot_id       = out_r.slot;
  assign outgoing_total    = out_r.total;
  assign ambiguous         = out_r.amb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enabled    <= 1'b1;
      max_age    <= DEF_MAX_AGE;
      open_count <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      last       <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          REG_ENABLED: enabled <= pwdata[0];
          default:     max_age <= pwdata[7:0];
        endcase
      end

      if (out_load) begin
        out_r     <= pend;
        last      <= state == S_DRAIN;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= op_t'(operation);
            r_form  <= form_id;
            r_delta <= delta;
            r_tag   <= requester_tag;
            r_use   <= is_use;
            r_uid   <= request_uid;
            r_sig   <= request_sig;
            r_slot  <= slot_id;
            left    <= cancel_count;
            state   <= S_START;
          end
        end
        S_START: begin
          rd       <= '0;
          wr       <= '0;
          n        <= '0;
          cand     <= '0;
          expiring <= 1'b1;
          total    <= '0;
          if (op == OP_CLEAR) begin
            open_count <= '0;
            state      <= S_IDLE;
          end else if (!enabled) begin
            if (op == OP_CONFIRM) begin
              pend       <= '{kind: KIND_NO_MATCH, form: r_form, delta: r_delta,
                              default: '0};
              pend_valid <= 1'b1;
              state      <= S_DRAIN;
            end else begin
              state <= S_IDLE;
            end
          end else if (op == OP_SUBMIT) begin
            if (sub_we) begin
              open_count <= open_count + 1'b1;
              state      <= S_IDLE;
            end else if (r_delta != 16'sd0) begin
              pend       <= '{kind: KIND_FULL, form: r_form, delta: r_delta, tag: r_tag,
                              uid: r_uid, sig: r_sig, slot: r_slot, default: '0};
              pend_valid <= 1'b1;
              state      <= S_DRAIN;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= (open_count == '0) ? S_FIN : S_RD;
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          if (ev_go) begin
            if (ev_emit) begin
              pend       <= ev_res;
              pend_valid <= 1'b1;
              n          <= n + 1'b1;
            end
            if (ev_keep) wr <= wr + 1'b1;
            if (op == OP_CONFIRM && is_match) begin
              if (cand == 2'd0) first <= e;
              if (cand != 2'd2) cand <= cand + 2'd1;
            end
            if (op == OP_CANCEL && ev_emit) left <= left - take;
            if (op == OP_COUNT && outg) begin
              total <= (sum > 21'(TOTAL_MAX)) ? TOTAL_MAX : sum[19:0];
            end
            if (op == OP_TICK && !(ev_emit && !ev_keep)) expiring <= 1'b0;
            rd <= rd + 1'b1;
            if (rd + 1'b1 == open_count) begin
              open_count <= ev_keep ? wr + 1'b1 : wr;
              state      <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (op == OP_CONFIRM) begin
            pend_valid <= 1'b1;
            if (cand == 2'd0) begin
              pend <= '{kind: KIND_NO_MATCH, form: r_form, delta: r_delta, default: '0};
            end else begin
              pend <= '{kind: KIND_CONFIRMED, form: first.form, delta: first.delta,
                        tag: first.tag, uid: first.uid, sig: first.sig,
                        slot: first.slot, total: 20'd0, amb: cand == 2'd2};
            end
          end else if (op == OP_COUNT) begin
            pend_valid <= 1'b1;
            pend       <= '{kind: KIND_OUTGOING, form: r_form, total: total, default: '0};
          end
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/prm_ram.sv @@
`timescale 1ns / 1ps
module prm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
